// File: design/masked_tint_wipe_defines.svh
// Assertion macros for the checker file of the masked tint wipe block.
// No dependencies; included by name where assertions are written.
`ifndef MASKED_TINT_WIPE_DEFINES_SVH
`define MASKED_TINT_WIPE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define MTW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define MTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/mtw_pkg.sv
// Shared types, codes and helper functions of the masked tint wipe block.
// No dependencies; imported by the controller, the datapath and the top level.
package mtw_pkg;

   // Word kinds carried on the request tuser.
   localparam logic OP_MASK_WRITE = 1'b0;
   localparam logic OP_PIXEL      = 1'b1;

   // Configuration port geometry and register indexes.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRESS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT_RGBA    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_VALID   = 3'd6;

   // Field widths.
   localparam int MIDX_W     = 12;
   localparam int MVAL_W     = 8;
   localparam int PIX_W      = 32;
   localparam int CNT_W      = 12;
   localparam int IMG_SIDE_W = 13;
   localparam int MSK_SIDE_W = 7;
   localparam int REQ_DATA_W = 56;

   // Position scaling: count times mask side, divided one bit per cycle.
   localparam int NUM_W     = CNT_W + MSK_SIDE_W;
   localparam int DIV_CNT_W = 5;
   localparam int MADDR_W   = 2 * MSK_SIDE_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_pix;
      logic mask_wr;
      logic div_step;
      logic calc_addr;
      logic mem_rd;
      logic tint;
      logic mix;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
   } dp_status_type;

   // Floor of x / 255, exact while the quotient stays at or below 255.
   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [17:0] s;
      s = {1'b0, x} + 18'd1 + {9'b0, x[16:8]};
      return s[15:8];
   endfunction

endpackage

// File: design/mtw_ctrl.sv
// Sequencing state machine of the masked tint wipe block.
// Depends on mtw_pkg; drives the datapath through dp_cmd_type commands.
module mtw_ctrl
   import mtw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_opcode,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_ADDR = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_TINT = 3'd4;
   localparam logic [2:0] S_MIX  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_opcode == OP_PIXEL) begin
                  cmd.load_pix = 1'b1;
                  step_in      = '0;
                  state_in     = S_DIV;
               end else begin
                  cmd.mask_wr = 1'b1;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = S_ADDR;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ADDR: begin
            cmd.calc_addr = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_TINT;
         end
         S_TINT: begin
            cmd.tint = 1'b1;
            state_in = S_MIX;
         end
         S_MIX: begin
            cmd.mix  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold the finished word until the output register can take it.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// File: design/mtw_datapath.sv
// Datapath of the masked tint wipe block: registers, counters, mask memory,
// position divider, blend lanes and output register. Depends on mtw_pkg.
module mtw_datapath
   import mtw_pkg::*;
#(
   parameter int MASK_SIDE_MAX  = 64,
   parameter int IMAGE_SIDE_MAX = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int STORE_DEPTH = MASK_SIDE_MAX * MASK_SIDE_MAX;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Request word fields.
   logic [MIDX_W-1:0] req_midx;
   logic [MVAL_W-1:0] req_mval;
   logic [PIX_W-1:0]  req_pix;

   assign req_midx = req_tdata[MIDX_W-1:0];
   assign req_mval = req_tdata[MIDX_W+MVAL_W-1:MIDX_W];
   assign req_pix  = req_tdata[MIDX_W+MVAL_W+PIX_W-1:MIDX_W+MVAL_W];

   // Configuration registers.
   logic [7:0]            progress_ff, progress_in;
   logic [PIX_W-1:0]      tint_ff, tint_in;
   logic [IMG_SIDE_W-1:0] img_w_ff, img_w_in, img_h_ff, img_h_in;
   logic [MSK_SIDE_W-1:0] msk_w_ff, msk_w_in, msk_h_ff, msk_h_in;
   logic                  msk_vld_ff, msk_vld_in;

   always_comb begin
      progress_in = progress_ff;
      tint_in     = tint_ff;
      img_w_in    = img_w_ff;
      img_h_in    = img_h_ff;
      msk_w_in    = msk_w_ff;
      msk_h_in    = msk_h_ff;
      msk_vld_in  = msk_vld_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PROGRESS:     progress_in = csr_wdata[7:0];
            CSR_TINT_RGBA:    tint_in     = csr_wdata[PIX_W-1:0];
            CSR_IMAGE_WIDTH:  img_w_in    = csr_wdata[IMG_SIDE_W-1:0];
            CSR_IMAGE_HEIGHT: img_h_in    = csr_wdata[IMG_SIDE_W-1:0];
            CSR_MASK_WIDTH:   msk_w_in    = csr_wdata[MSK_SIDE_W-1:0];
            CSR_MASK_HEIGHT:  msk_h_in    = csr_wdata[MSK_SIDE_W-1:0];
            CSR_MASK_VALID:   msk_vld_in  = csr_wdata[0];
            default:          msk_vld_in  = msk_vld_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         tint_ff     <= 32'h00FF_00FF;
         img_w_ff    <= 13'd1;
         img_h_ff    <= 13'd1;
         msk_w_ff    <= '0;
         msk_h_ff    <= '0;
         msk_vld_ff  <= 1'b0;
      end else begin
         progress_ff <= progress_in;
         tint_ff     <= tint_in;
         img_w_ff    <= img_w_in;
         img_h_ff    <= img_h_in;
         msk_w_ff    <= msk_w_in;
         msk_h_ff    <= msk_h_in;
         msk_vld_ff  <= msk_vld_in;
      end
   end

   // Effective sizes: image sides clamp to 1..max, mask sides to 0..max.
   logic [IMG_SIDE_W-1:0] iw, ih;
   logic [MSK_SIDE_W-1:0] mw, mh;

   always_comb begin
      if (img_w_ff == '0) begin
         iw = IMG_SIDE_W'(1);
      end else if (32'(img_w_ff) > 32'(IMAGE_SIDE_MAX)) begin
         iw = IMG_SIDE_W'(IMAGE_SIDE_MAX);
      end else begin
         iw = img_w_ff;
      end
      if (img_h_ff == '0) begin
         ih = IMG_SIDE_W'(1);
      end else if (32'(img_h_ff) > 32'(IMAGE_SIDE_MAX)) begin
         ih = IMG_SIDE_W'(IMAGE_SIDE_MAX);
      end else begin
         ih = img_h_ff;
      end
      mw = (32'(msk_w_ff) > 32'(MASK_SIDE_MAX)) ? MSK_SIDE_W'(MASK_SIDE_MAX) : msk_w_ff;
      mh = (32'(msk_h_ff) > 32'(MASK_SIDE_MAX)) ? MSK_SIDE_W'(MASK_SIDE_MAX) : msk_h_ff;
   end

   // Raster position counters and end-of-frame flag for the taken pixel.
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;
   logic             col_wrap, row_wrap;

   assign col_wrap = ({1'b0, col_ff} + 13'd1) >= iw;
   assign row_wrap = ({1'b0, row_ff} + 13'd1) >= ih;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.load_pix) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Mask memory: one write port from the request, one registered read.
   logic [7:0]  mask_mem [STORE_DEPTH];
   logic [7:0]  mask_rd_ff;
   logic [31:0] wr_idx_ext, rd_idx_ext;
   logic        wr_ok;
   logic [MADDR_W-1:0] addr_ff, addr_in;

   assign wr_idx_ext = 32'(req_midx);
   assign wr_ok      = wr_idx_ext < 32'(STORE_DEPTH);
   assign rd_idx_ext = 32'(addr_ff);

   always_ff @(posedge clock) begin
      if (cmd.mask_wr && wr_ok) begin
         mask_mem[wr_idx_ext[ADDR_W-1:0]] <= req_mval;
      end
      if (cmd.mem_rd) begin
         mask_rd_ff <= mask_mem[rd_idx_ext[ADDR_W-1:0]];
      end
   end

   // Position divider: two restoring lanes, one quotient bit per cycle.
   // The numerator register shifts out dividend bits and takes quotient bits.
   logic [NUM_W-1:0]      num_x_ff, num_x_in, num_y_ff, num_y_in;
   logic [IMG_SIDE_W-1:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [IMG_SIDE_W:0]   rem_x_sh, rem_y_sh;

   assign rem_x_sh = {rem_x_ff, num_x_ff[NUM_W-1]};
   assign rem_y_sh = {rem_y_ff, num_y_ff[NUM_W-1]};

   always_comb begin
      num_x_in = num_x_ff;
      num_y_in = num_y_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      if (cmd.load_pix) begin
         num_x_in = NUM_W'(col_ff) * NUM_W'(mw);
         num_y_in = NUM_W'(row_ff) * NUM_W'(mh);
         rem_x_in = '0;
         rem_y_in = '0;
      end else if (cmd.div_step) begin
         if (rem_x_sh >= {1'b0, iw}) begin
            rem_x_in = IMG_SIDE_W'(rem_x_sh - {1'b0, iw});
            num_x_in = {num_x_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_x_in = rem_x_sh[IMG_SIDE_W-1:0];
            num_x_in = {num_x_ff[NUM_W-2:0], 1'b0};
         end
         if (rem_y_sh >= {1'b0, ih}) begin
            rem_y_in = IMG_SIDE_W'(rem_y_sh - {1'b0, ih});
            num_y_in = {num_y_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_y_in = rem_y_sh[IMG_SIDE_W-1:0];
            num_y_in = {num_y_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      num_x_ff <= num_x_in;
      num_y_ff <= num_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
   end

   // Mask coordinates saturate to the last texel, then form the raster address.
   logic [MSK_SIDE_W-1:0] mx, my;
   logic                  use_mask_ff, use_mask_in;

   assign mx = (num_x_ff >= NUM_W'(mw)) ? MSK_SIDE_W'(mw - 1'b1)
                                        : num_x_ff[MSK_SIDE_W-1:0];
   assign my = (num_y_ff >= NUM_W'(mh)) ? MSK_SIDE_W'(mh - 1'b1)
                                        : num_y_ff[MSK_SIDE_W-1:0];

   always_comb begin
      addr_in     = addr_ff;
      use_mask_in = use_mask_ff;
      if (cmd.calc_addr) begin
         addr_in     = MADDR_W'(MADDR_W'(my) * MADDR_W'(mw) + MADDR_W'(mx));
         use_mask_in = (mw != '0) && (mh != '0);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      use_mask_ff <= use_mask_in;
   end

   // Pixel word and end-of-frame flag held for the item at work.
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             eof_ff, eof_in;

   assign pix_in = cmd.load_pix ? req_pix : pix_ff;
   assign eof_in = cmd.load_pix ? (col_wrap && row_wrap) : eof_ff;

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      eof_ff <= eof_in;
   end

   // Blend lanes, one per channel: tint product, then the two weighted terms.
   logic [7:0]       mval;
   logic             blend_ff, blend_in;
   logic [3:0][7:0]  tinted_ff, tinted_in;
   logic [3:0][15:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [3:0][7:0]  mixed;
   logic [7:0]       inv_p;

   assign mval     = use_mask_ff ? mask_rd_ff : 8'd0;
   assign inv_p    = 8'd255 - progress_ff;
   assign blend_in = cmd.tint ? (msk_vld_ff && (progress_ff != '0) && (mval <= progress_ff))
                              : blend_ff;

   always_comb begin
      for (int ch = 0; ch < 4; ch++) begin
         tinted_in[ch] = cmd.tint
            ? div255(17'(pix_ff[8*ch +: 8] * tint_ff[8*ch +: 8]) + 17'd127)
            : tinted_ff[ch];
         prod_a_in[ch] = cmd.mix ? 16'(pix_ff[8*ch +: 8] * inv_p) : prod_a_ff[ch];
         prod_b_in[ch] = cmd.mix ? 16'(tinted_ff[ch] * progress_ff) : prod_b_ff[ch];
         mixed[ch]     = div255(17'(prod_a_ff[ch]) + 17'(prod_b_ff[ch]) + 17'd127);
      end
   end

   always_ff @(posedge clock) begin
      blend_ff  <= blend_in;
      tinted_ff <= tinted_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   // Output register: takes a finished word while the receiver is free.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = blend_ff ? mixed : pix_ff;
         rsp_last_in  = eof_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tlast       = rsp_last_ff;

endmodule

// File: design/masked_tint_wipe.sv
// Luma-mask wipe over a raster pixel stream: request and response stream
// channels plus a write-only register port. Using the block:
//  - req words with tuser = 0 write one texel into the mask memory and give
//    no response word.
//  - req words with tuser = 1 carry one RGBA8888 pixel in raster order. The
//    block tracks column and row, looks up the mask texel by nearest
//    neighbour, and blends the pixel toward pixel times tint by progress where
//    the mask is valid, progress nonzero and the texel at or below progress.
//  - Each pixel gives one rsp word, tlast set on the last pixel of a frame.
//    A new pixel is taken only after the last one has gone into the output
//    register. Each pixel passes one accept step, the 19-step shift-subtract
//    divider that scales the position onto the mask, then the address, memory
//    read, two multiply stages and the output load.
//  - A finished word waits in the output register while the receiver stalls;
//    the next pixel is taken and worked on meanwhile, and it waits in the
//    last stage until the output register is free.
//  - Reset clears the counters, the state machine, the output register and
//    the registers to their defaults. The mask memory is not cleared.
//  - The user must write registers only while no pixel is in flight; the block does not enforce it.
module masked_tint_wipe
   import mtw_pkg::*;
#(
   parameter int MASK_SIDE_MAX  = 64,
   parameter int IMAGE_SIDE_MAX = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // mask_index[11:0], mask_value[19:12], pixel_rgba[51:20], zero[55:52]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_rgba[31:0]
   output logic [PIX_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing.
   mtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   mtw_datapath #(
      .MASK_SIDE_MAX  (MASK_SIDE_MAX),
      .IMAGE_SIDE_MAX (IMAGE_SIDE_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/mtw_checker.sv
// Port-level checks on the masked tint wipe block, bound to its top level.
// Depends on masked_tint_wipe_defines.svh for the assertion macros.
`include "masked_tint_wipe_defines.svh"

module mtw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled response word holds its contents.
   `MTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "response word changed while stalled")

   // Nothing is in flight when a word is taken, so no response can follow at once.
   `MTW_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid, "response appeared one cycle after a request word")

   // A pixel occupies the block, so the request side closes right after it.
   `MTW_ASSERT_NEXT(a_busy_after_pixel, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "request side stayed open after a pixel word")

   // Reset leaves the block idle with an empty output register.
   `MTW_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready, "block not idle after reset")

endmodule

bind masked_tint_wipe mtw_checker u_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the masked tint wipe block: drives mask and pixel words,
// predicts every output pixel, and checks it as it leaves the block.
// Depends on mtw_pkg and the masked_tint_wipe top level only.
module testbench;
   import mtw_pkg::*;

   localparam int MASK_SIDE  = 64;
   localparam int IMAGE_SIDE = 4096;
   localparam int STORE_SIZE = MASK_SIDE * MASK_SIDE;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_WORDS = 1850;
   // Cycles to let pass once nothing is expected.
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [7:0]  progress;
      logic [31:0] tint_rgba;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic [6:0]  mask_width;
      logic [6:0]  mask_height;
      logic        mask_valid;
   } wipe_cfg_type;

   typedef struct {
      logic [31:0] rgba;
      logic        frame_end;
   } wipe_pixel_type;

   // Predicts the output pixel of every accepted pixel word and checks the outputs.
   class tint_wipe_checker;
      logic [7:0]     texel_mem [STORE_SIZE];
      bit             texel_loaded [STORE_SIZE];
      int unsigned    column_pos;
      int unsigned    row_pos;
      wipe_cfg_type   cfg;
      wipe_pixel_type pixels_due [$];
      int             errors;

      function new();
         column_pos = 0;
         row_pos = 0;
         errors = 0;
         cfg.progress = 8'd0;
         cfg.tint_rgba = 32'h00FF00FF;
         cfg.image_width = 13'd1;
         cfg.image_height = 13'd1;
         cfg.mask_width = 7'd0;
         cfg.mask_height = 7'd0;
         cfg.mask_valid = 1'b0;
      endfunction

      function int unsigned side_limit(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      // Mask texel read by the next pixel, or -1 when that pixel reads none.
      function int texel_address();
         int unsigned iw, ih, mw, mh, mx, my;
         if (cfg.mask_valid == 1'b0 || cfg.progress == 8'd0) return -1;
         mw = side_limit(32'(cfg.mask_width), 0, MASK_SIDE);
         mh = side_limit(32'(cfg.mask_height), 0, MASK_SIDE);
         if (mw == 0 || mh == 0) return -1;
         iw = side_limit(32'(cfg.image_width), 1, IMAGE_SIDE);
         ih = side_limit(32'(cfg.image_height), 1, IMAGE_SIDE);
         mx = column_pos * mw / iw;
         my = row_pos * mh / ih;
         // A counter left beyond the image after a size change clamps to the last texel.
         if (mx >= mw) mx = mw - 1;
         if (my >= mh) my = mh - 1;
         return int'(my * mw + mx);
      endfunction

      // Rounded unorm8 blend of one channel toward channel times tint.
      function logic [7:0] mix_channel(int unsigned c, int unsigned t, int unsigned p);
         int unsigned tinted;
         tinted = (c * t + 127) / 255;
         return 8'((c * (255 - p) + tinted * p + 127) / 255);
      endfunction

      function void take_word(logic op, logic [11:0] index, logic [7:0] value,
                              logic [31:0] pixel);
         int             addr;
         int unsigned    iw, ih;
         logic [7:0]     texel;
         wipe_pixel_type out;
         if (op == OP_MASK_WRITE) begin
            texel_mem[index] = value;
            texel_loaded[index] = 1'b1;
            return;
         end
         addr = texel_address();
         texel = (addr >= 0) ? texel_mem[addr] : 8'd0;
         out.rgba = pixel;
         if (cfg.mask_valid && cfg.progress != 8'd0 && texel <= cfg.progress) begin
            for (int sh = 0; sh < 32; sh += 8)
               out.rgba[sh +: 8] = mix_channel(32'(pixel[sh +: 8]),
                                               32'(cfg.tint_rgba[sh +: 8]),
                                               32'(cfg.progress));
         end
         // Raster position advances on every pixel, blended or not.
         iw = side_limit(32'(cfg.image_width), 1, IMAGE_SIDE);
         ih = side_limit(32'(cfg.image_height), 1, IMAGE_SIDE);
         out.frame_end = 1'b0;
         if (column_pos + 1 >= iw) begin
            column_pos = 0;
            if (row_pos + 1 >= ih) begin
               row_pos = 0;
               out.frame_end = 1'b1;
            end else begin
               row_pos = (row_pos + 1) & 32'hFFF;
            end
         end else begin
            column_pos = (column_pos + 1) & 32'hFFF;
         end
         pixels_due.push_back(out);
      endfunction

      function void check_pixel(logic [31:0] rgba, logic frame_end);
         wipe_pixel_type want;
         if (pixels_due.size() == 0) begin
            $display("%0t: unexpected pixel word %h", $time, rgba);
            errors++;
            return;
         end
         want = pixels_due.pop_front();
         if (rgba !== want.rgba) begin
            $display("%0t: result_rgba expected %h actual %h", $time, want.rgba, rgba);
            errors++;
         end
         if (frame_end !== want.frame_end) begin
            $display("%0t: end_of_frame expected %b actual %b", $time, want.frame_end,
                     frame_end);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_PIXEL;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PROGRESS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tint_wipe_checker wipe_check = new();
   int words_sent = 0;
   int burst_left = 0;
   int gap_max = 0;
   int cycle_count = 0;
   logic [31:0] stall_pattern = 32'hFFFFFFFF;
   logic [5:0]  stall_tick = '0;

   masked_tint_wipe uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Receiver readiness follows a rotating pattern that is redrawn each time stall_tick wraps to zero.
   always @(posedge clock) begin
      if (stall_tick == 6'd0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= 32'hFFFFFFFF;
            1: stall_pattern <= $urandom | 32'h1;
            2: stall_pattern <= ($urandom & $urandom) | 32'h1;
            default: stall_pattern <= $urandom | $urandom;
         endcase
      end else begin
         stall_pattern <= {stall_pattern[30:0], stall_pattern[31]};
      end
      stall_tick <= stall_tick + 6'd1;
      rsp_tready <= stall_pattern[0];
   end

   // Every output word taken by the receiver is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         wipe_check.check_pixel(rsp_tdata, rsp_tlast);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offers one word, with a random gap whenever a burst runs out, and waits for it to go.
   task automatic send_word(input logic op, input logic [11:0] index,
                            input logic [7:0] value, input logic [31:0] pixel);
      int gap;
      if (burst_left <= 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = (gap_max == 0) ? 1000 : $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, pixel, value, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      wipe_check.take_word(op, index, value, pixel);
      words_sent++;
   endtask

   // Sends a pixel, first loading the texel it will read if that texel is still unwritten.
   task automatic send_pixel(input logic [31:0] pixel);
      int addr;
      addr = wipe_check.texel_address();
      if (addr >= 0 && !wipe_check.texel_loaded[addr])
         send_word(OP_MASK_WRITE, addr[11:0], 8'($urandom), $urandom);
      send_word(OP_PIXEL, 12'($urandom), 8'($urandom), pixel);
   endtask

   // Stops sending and waits until the block has delivered everything and gone quiet.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (wipe_check.pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all seven registers, one per cycle.
   task automatic apply_cfg(input wipe_cfg_type c);
      logic [CSR_IDX_W-1:0]  regs [7];
      logic [CSR_DATA_W-1:0] vals [7];
      regs[0] = CSR_PROGRESS;     vals[0] = CSR_DATA_W'(c.progress);
      regs[1] = CSR_TINT_RGBA;    vals[1] = CSR_DATA_W'(c.tint_rgba);
      regs[2] = CSR_IMAGE_WIDTH;  vals[2] = CSR_DATA_W'(c.image_width);
      regs[3] = CSR_IMAGE_HEIGHT; vals[3] = CSR_DATA_W'(c.image_height);
      regs[4] = CSR_MASK_WIDTH;   vals[4] = CSR_DATA_W'(c.mask_width);
      regs[5] = CSR_MASK_HEIGHT;  vals[5] = CSR_DATA_W'(c.mask_height);
      regs[6] = CSR_MASK_VALID;   vals[6] = CSR_DATA_W'(c.mask_valid);
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      wipe_check.cfg = c;
   endtask

   function automatic wipe_cfg_type make_cfg(logic [7:0] p, logic [31:0] t,
                                             logic [12:0] iw, logic [12:0] ih,
                                             logic [6:0] mw, logic [6:0] mh, logic v);
      wipe_cfg_type c;
      c.progress = p;
      c.tint_rgba = t;
      c.image_width = iw;
      c.image_height = ih;
      c.mask_width = mw;
      c.mask_height = mh;
      c.mask_valid = v;
      return c;
   endfunction

   // Mostly small images, now and then zero, the maximum or an oversized value.
   function automatic logic [12:0] pick_image_side();
      case ($urandom_range(0, 15))
         0: return 13'd0;
         1: return 13'(IMAGE_SIDE);
         2: return 13'($urandom_range(IMAGE_SIDE + 1, 8191));
         3: return 13'($urandom_range(7, 40));
         default: return 13'($urandom_range(1, 6));
      endcase
   endfunction

   function automatic logic [6:0] pick_mask_side();
      case ($urandom_range(0, 11))
         0: return 7'd0;
         1: return 7'(MASK_SIDE);
         2: return 7'($urandom_range(MASK_SIDE + 1, 127));
         3: return 7'($urandom_range(9, MASK_SIDE - 1));
         default: return 7'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic wipe_cfg_type random_cfg();
      logic [7:0]  p;
      logic [31:0] t;
      case ($urandom_range(0, 7))
         0: p = 8'd0;
         1: p = 8'd255;
         default: p = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: t = 32'h00000000;
         1: t = 32'hFFFFFFFF;
         default: t = $urandom;
      endcase
      return make_cfg(p, t, pick_image_side(), pick_image_side(), pick_mask_side(),
                      pick_mask_side(), $urandom_range(0, 3) != 0);
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return 32'h00000000;
         1: return 32'hFFFFFFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      wipe_cfg_type c;
      int           region;
      int           pixel_count;
      int           mw, mh;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: no mask, so every pixel passes and each one closes a 1x1 frame.
      send_pixel(32'h00000000);
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'h12345678);
      wait_drained();

      // 2x2 mask over a 2x2 image: texels below, equal to and above progress.
      apply_cfg(make_cfg(8'd200, 32'h00000000, 13'd2, 13'd2, 7'd2, 7'd2, 1'b1));
      send_word(OP_MASK_WRITE, 12'd0, 8'd0, 32'h0);
      send_word(OP_MASK_WRITE, 12'd1, 8'd255, 32'hFFFFFFFF);
      send_word(OP_MASK_WRITE, 12'd2, 8'd200, 32'h0);
      send_word(OP_MASK_WRITE, 12'd3, 8'd201, 32'h0);
      send_word(OP_MASK_WRITE, 12'hFFF, 8'd255, 32'h0);
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'h80808080);
      send_pixel(32'h00000000);
      wait_drained();

      // Zero width taken as one, oversized height and mask width, zero mask height.
      apply_cfg(make_cfg(8'd255, 32'h12345678, 13'd0, 13'd8191, 7'd127, 7'd0, 1'b1));
      send_pixel(32'hF0E1D2C3);
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'h01020304);
      wait_drained();

      // Zero progress passes pixels through; the row left beyond the new height ends
      // the frame at the end of this line.
      apply_cfg(make_cfg(8'd0, 32'hFFFFFFFF, 13'd3, 13'd2, 7'd2, 7'd2, 1'b1));
      for (int i = 0; i < 4; i++) send_pixel(random_pixel());
      wait_drained();

      // Random phases: at times a mask load over a small mask area, then pixels with stray texel writes.
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         c = random_cfg();
         apply_cfg(c);
         case ($urandom_range(0, 3))
            0: gap_max = 0;
            1: gap_max = 4;
            2: gap_max = 12;
            default: gap_max = 30;
         endcase
         mw = (int'(c.mask_width) > MASK_SIDE) ? MASK_SIDE : int'(c.mask_width);
         mh = (int'(c.mask_height) > MASK_SIDE) ? MASK_SIDE : int'(c.mask_height);
         region = mw * mh;
         if (c.mask_valid && region > 0 && region <= 64 && $urandom_range(0, 2) != 0) begin
            for (int i = 0; i < region; i++)
               send_word(OP_MASK_WRITE, 12'(i), 8'($urandom), $urandom);
         end
         pixel_count = $urandom_range(4, 48);
         for (int k = 0; k < pixel_count; k++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(OP_MASK_WRITE, 12'($urandom), 8'($urandom), $urandom);
            send_pixel(random_pixel());
         end
         wait_drained();
      end

      if (wipe_check.errors == 0 && wipe_check.pixels_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: masked_tint_wipe.f
+incdir+design
design/mtw_pkg.sv
design/mtw_ctrl.sv
design/mtw_datapath.sv
design/masked_tint_wipe.sv
design/mtw_checker.sv
sim/testbench.sv
